FILE: src/krt_pkg.sv
// Package for the keyed record table: operation and status codes, and the
// packed item types of the command and result channels. No dependencies.
package krt_pkg;

    // Operation codes carried in the command item.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    // Status codes carried in the result item.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // One command item.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] quantity_in;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] quantity_out;
        logic [6:0]         slot_index;
        logic [7:0]         entry_count;
    } rsp_t;

    // One stored record.
    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] quantity;
    } entry_t;

endpackage

FILE: src/keyed_record_table.sv
// Keyed record table: an unsorted, insertion-ordered table of key/quantity
// records held in one single-port-read memory, searched by a small sequencer.
// Depends on krt_pkg for item types and codes.
//
//   channel   ports                     flow
//   command   start, busy, cmd          taken when start is high and busy low
//   result    rsp_valid, rsp            shown for one cycle, no back-pressure
//
// Insert, and any search of an empty table, is answered from idle with busy
// kept low. Lookup and update pass a read and compare state per entry scanned
// up to and including the match (or all held entries on a miss). Delete adds a
// shift read and a shift write state per later entry shifted down. The single
// memory read port sets this: each step waits on a read. Results appear the
// cycle after the last step. Reset clears count, sequencer, rsp_valid only.
module keyed_record_table #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  krt_pkg::cmd_t cmd,
    output logic          rsp_valid,
    output krt_pkg::rsp_t rsp
);
    import krt_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN_RD  = 5'b00010,
        S_SCAN_CMP = 5'b00100,
        S_SHIFT_RD = 5'b01000,
        S_SHIFT_WR = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] qty_reg, qty_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CW-1:0]      idx_plus1;
    logic [IW-1:0]      rd_addr;
    entry_t             rd_data_reg;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    entry_t             wr_data;
    entry_t             mem [DEPTH];

    assign idx_plus1 = idx_reg + CW'(1);
    assign busy      = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Record memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        qty_next       = qty_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        rd_addr        = idx_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IW-1:0];
        wr_data        = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.op;
                    key_next = cmd.key;
                    qty_next = cmd.quantity_in;
                    rsp_next.status       = ST_DONE;
                    rsp_next.quantity_out = '0;
                    rsp_next.slot_index   = '0;
                    rsp_next.entry_count  = 8'(count_reg);
                    if (cmd.op == OP_INSERT)
                    begin
                        rsp_valid_next = 1'b1;
                        if (count_reg == CW'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = count_reg[IW-1:0];
                            wr_data.key      = cmd.key;
                            wr_data.quantity = cmd.quantity_in;
                            count_next    = count_reg + CW'(1);
                            rsp_next.slot_index  = 7'(count_reg);
                            rsp_next.entry_count = 8'(count_reg + CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_next.status = ST_MISS;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end

            // Compare the fetched key; on a hit act on the slot, else move on.
            S_SCAN_CMP:
            begin
                if (rd_data_reg.key == key_reg)
                begin
                    rsp_next.status       = ST_DONE;
                    rsp_next.quantity_out = rd_data_reg.quantity;
                    rsp_next.slot_index   = 7'(idx_reg);
                    rsp_next.entry_count  = 8'(count_reg);
                    case (op_reg)
                        OP_UPDATE:
                        begin
                            wr_en            = 1'b1;
                            wr_data.key      = key_reg;
                            wr_data.quantity = qty_reg;
                            rsp_valid_next   = 1'b1;
                            state_next       = S_IDLE;
                        end
                        OP_DELETE:
                        begin
                            if (idx_plus1 < count_reg)
                            begin
                                state_next = S_SHIFT_RD;
                            end
                            else
                            begin
                                count_next           = count_reg - CW'(1);
                                rsp_next.entry_count = 8'(count_reg - CW'(1));
                                rsp_valid_next       = 1'b1;
                                state_next           = S_IDLE;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
                else if (idx_plus1 == count_reg)
                begin
                    rsp_next.status       = ST_MISS;
                    rsp_next.quantity_out = '0;
                    rsp_next.slot_index   = '0;
                    rsp_next.entry_count  = 8'(count_reg);
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_plus1;
                    state_next = S_SCAN_RD;
                end
            end

            // Fetch the record one slot above the hole.
            S_SHIFT_RD:
            begin
                rd_addr    = idx_plus1[IW-1:0];
                state_next = S_SHIFT_WR;
            end

            // Move it down; finish once the last held record has moved.
            S_SHIFT_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_plus1;
                if ((idx_plus1 + CW'(1)) < count_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next           = count_reg - CW'(1);
                    rsp_next.entry_count = 8'(count_reg - CW'(1));
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        qty_reg <= qty_next;
        rsp_reg <= rsp_next;
    end

`ifndef NO_ASSERTIONS
    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // A result is only shown while the sequencer is back in idle.
    a_rsp_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (state_reg == S_IDLE))
        else $error("result issued while sequencer busy");

    // An accepted insert into a table with room grows the count by one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_INSERT && count_reg != CW'(DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the count");

    // The scan pointer stays inside the held entries.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_SCAN_CMP) |-> (idx_reg < count_reg))
        else $error("scan pointer beyond held entries");

    // A miss or full result carries no quantity and no slot.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != ST_DONE)
        |-> (rsp_reg.quantity_out == '0 && rsp_reg.slot_index == '0))
        else $error("failed operation returned data");
`endif

endmodule

FILE: test/keyed_record_table_test.sv
// Self-checking testbench for the keyed record table: drives insert, lookup,
// update and delete items and checks every result against its own table copy.
// Depends on krt_pkg and keyed_record_table.
module keyed_record_table_test;
    import krt_pkg::*;

    localparam int TABLE_DEPTH = 128;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    cmd_t  cmd;
    logic  rsp_valid;
    rsp_t  rsp;

    // Shadow copy of the table, updated when an item is accepted.
    logic signed [31:0] table_keys [TABLE_DEPTH];
    logic signed [31:0] table_qtys [TABLE_DEPTH];
    int                 table_count;

    // Results still owed by the block, oldest first.
    rsp_t expected_results[$];
    int   error_count;

    // Sender idling controls.
    int gap_pct;
    int burst_left;

    keyed_record_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp      (rsp)
    );

    // Clock with a period of 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

    // Apply one operation to the shadow table and return the result it owes.
    function automatic rsp_t predict_result(input cmd_t item);
        rsp_t r;
        int   hit;
        r = '0;
        r.status = ST_DONE;
        if (item.op == OP_INSERT)
        begin
            if (table_count >= TABLE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                r.slot_index = 7'(table_count);
                table_keys[table_count] = item.key;
                table_qtys[table_count] = item.quantity_in;
                table_count++;
            end
        end
        else
        begin
            // The lowest matching slot wins when keys repeat.
            hit = -1;
            for (int i = 0; i < table_count; i++)
            begin
                if (table_keys[i] == item.key)
                begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0)
            begin
                r.status = ST_MISS;
            end
            else
            begin
                r.slot_index = 7'(hit);
                r.quantity_out = table_qtys[hit];
                if (item.op == OP_UPDATE)
                begin
                    table_qtys[hit] = item.quantity_in;
                end
                else if (item.op == OP_DELETE)
                begin
                    for (int i = hit; i + 1 < table_count; i++)
                    begin
                        table_keys[i] = table_keys[i + 1];
                        table_qtys[i] = table_qtys[i + 1];
                    end
                    table_count--;
                end
            end
        end
        r.entry_count = 8'(table_count);
        return r;
    endfunction

    function automatic cmd_t make_item(input logic [1:0] op, input logic signed [31:0] key,
                                       input logic signed [31:0] quantity);
        cmd_t item;
        item.op = op;
        item.key = key;
        item.quantity_in = quantity;
        return item;
    endfunction

    // Mostly keys already held, so that searches hit; some near-miss and wild keys.
    function automatic logic signed [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (table_count > 0 && roll < 60)
            return table_keys[$urandom_range(0, table_count - 1)];
        else if (roll < 85)
            return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        else
            return $urandom;
    endfunction

    function automatic logic signed [31:0] pick_quantity();
        case ($urandom_range(0, 19))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_val,
                                   input logic [31:0] act_val);
        report_failure($sformatf("%s expected %0h, got %0h", field, exp_val, act_val));
    endtask

    // Send one item, with an optional idle gap first, and wait for it to be taken.
    task automatic send_item(input cmd_t item);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if ($urandom_range(0, 19) == 0)
        begin
            burst_left = $urandom_range(10, 30);
        end
        else if ($urandom_range(0, 99) < gap_pct)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= item;
        do @(posedge clk); while (busy);
        expected_results.push_back(predict_result(item));
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Searches and deletes on an empty table all miss.
    task automatic test_empty_table();
        send_item(make_item(OP_LOOKUP, 32'sd0, 32'sd0));
        send_item(make_item(OP_UPDATE, 32'sd0, 32'sd5));
        send_item(make_item(OP_DELETE, 32'sd0, 32'sd0));
    endtask

    // Extreme keys and quantities through every operation, plus misses.
    task automatic test_field_extremes();
        send_item(make_item(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_item(make_item(OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_item(make_item(OP_INSERT, 32'sd0, 32'sd0));
        send_item(make_item(OP_INSERT, -32'sd1, -32'sd1));
        send_item(make_item(OP_LOOKUP, 32'sh8000_0000, 32'sh1234_5678));
        send_item(make_item(OP_LOOKUP, 32'sh7FFF_FFFF, 32'sd0));
        send_item(make_item(OP_UPDATE, 32'sh7FFF_FFFF, 32'sh5555_AAAA));
        send_item(make_item(OP_LOOKUP, 32'sh7FFF_FFFF, 32'sd0));
        send_item(make_item(OP_LOOKUP, 32'sd1, 32'sd0));
        send_item(make_item(OP_UPDATE, 32'sd1, 32'sd9));
        send_item(make_item(OP_DELETE, 32'sd1, 32'sd0));
        send_item(make_item(OP_DELETE, 32'sh8000_0000, 32'sd0));
    endtask

    // Repeated keys: only the lowest matching slot is touched.
    task automatic test_duplicate_keys();
        send_item(make_item(OP_INSERT, 32'sd7, 32'sd1));
        send_item(make_item(OP_INSERT, 32'sd7, 32'sd2));
        send_item(make_item(OP_LOOKUP, 32'sd7, 32'sd0));
        send_item(make_item(OP_UPDATE, 32'sd7, 32'sd3));
        send_item(make_item(OP_DELETE, 32'sd7, 32'sd0));
        send_item(make_item(OP_LOOKUP, 32'sd7, 32'sd0));
        send_item(make_item(OP_DELETE, -32'sd1, 32'sd0));
        send_item(make_item(OP_DELETE, 32'sd7, 32'sd0));
    endtask

    // Fill the table, bounce off the full limit, work at the ends, then empty it.
    task automatic test_full_table();
        drain_results();
        while (table_count < TABLE_DEPTH)
            send_item(make_item(OP_INSERT, pick_key(), pick_quantity()));
        repeat (3) send_item(make_item(OP_INSERT, pick_key(), pick_quantity()));
        send_item(make_item(OP_LOOKUP, table_keys[TABLE_DEPTH - 1], 32'sd0));
        send_item(make_item(OP_UPDATE, table_keys[TABLE_DEPTH - 1], pick_quantity()));
        send_item(make_item(OP_DELETE, table_keys[0], 32'sd0));
        send_item(make_item(OP_INSERT, pick_key(), pick_quantity()));
        send_item(make_item(OP_DELETE, table_keys[TABLE_DEPTH - 1], 32'sd0));
        send_item(make_item(OP_INSERT, $urandom, pick_quantity()));
        repeat (40) send_item(make_item(2'($urandom_range(1, 3)), pick_key(), pick_quantity()));
        while (table_count > 0)
            send_item(make_item(OP_DELETE, table_keys[$urandom_range(0, table_count - 1)],
                                pick_quantity()));
    endtask

    // Random operations steered toward a moving fill level.
    task automatic test_random_traffic(input int item_total, input int idle_pct);
        int fill_target;
        int roll;
        logic [1:0] op;
        gap_pct = idle_pct;
        burst_left = 0;
        fill_target = 4;
        for (int n = 0; n < item_total; n++)
        begin
            if (n % 40 == 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    fill_target = $urandom_range(0, 12);
                else if (roll < 96)
                    fill_target = $urandom_range(13, 60);
                else
                    fill_target = TABLE_DEPTH;
            end
            // Sometimes let everything settle before the next item.
            if ($urandom_range(0, 99) == 0)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < ((table_count < fill_target) ? 60 : 20))
                op = OP_INSERT;
            else
                op = 2'($urandom_range(1, 3));
            send_item(make_item(op, pick_key(), pick_quantity()));
        end
    endtask

    // Compare each result with the oldest owed one.
    always @(posedge clk)
    begin : check_results
        rsp_t exp_r;
        if (rst_n && rsp_valid)
        begin
            if (expected_results.size() == 0)
            begin
                report_failure($sformatf("stray result: status %0h qty %0h slot %0h count %0h",
                                         rsp.status, rsp.quantity_out, rsp.slot_index,
                                         rsp.entry_count));
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (rsp.status !== exp_r.status)
                    report_mismatch("status", 32'(exp_r.status), 32'(rsp.status));
                if (rsp.quantity_out !== exp_r.quantity_out)
                    report_mismatch("quantity_out", exp_r.quantity_out, rsp.quantity_out);
                if (rsp.slot_index !== exp_r.slot_index)
                    report_mismatch("slot_index", 32'(exp_r.slot_index), 32'(rsp.slot_index));
                if (rsp.entry_count !== exp_r.entry_count)
                    report_mismatch("entry_count", 32'(exp_r.entry_count), 32'(rsp.entry_count));
            end
        end
    end

    // Reset, then run every test in turn.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        table_count = 0;
        error_count = 0;
        gap_pct = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_duplicate_keys();
        test_full_table();
        test_random_traffic(180, 0);
        test_random_traffic(180, 53);
        test_random_traffic(180, 0);
        test_random_traffic(180, 9);

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
